// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the mixer RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RVM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RVM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/rvm_pkg.sv =====
// Shared types and constants for the resampling voice mixer.
// No dependencies.
`timescale 1ns / 1ps
package rvm_pkg;
  localparam int VOICES = 8;
  localparam int VW = 3;
  localparam int AW = 16;
  localparam int SAMPLE_WORDS = 65536;
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;
  localparam logic [16:0] VOL_UNITY = 17'd32768;

  // accumulator control from sequencer to mac unit
  typedef struct packed {
    logic clr;
    logic en;
    logic right;
  } mac_ctl_t;
endpackage

// ===== hw/rtl/rvm_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/rvm_mac.sv =====
// Shared multiply-accumulate unit: one lerp term per cycle into L/R accumulators.
// Depends on rvm_pkg.
`timescale 1ns / 1ps
module rvm_mac (
  input  logic              clk,
  input  rvm_pkg::mac_ctl_t ctl,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  input  logic [15:0]        frac,
  input  logic [16:0]        vol,
  output logic signed [15:0] left_q,
  output logic signed [15:0] right_q
);
  // v = a*65536 + (b-a)*frac ; fits 34 bits signed
  logic signed [16:0] diff;
  logic signed [33:0] prod_nxt, prod_r;
  logic signed [33:0] v;
  logic signed [51:0] term;
  logic signed [54:0] accl_r, accr_r;
  logic               en_d_r, right_d_r;
  logic signed [15:0] ql, qr;

  assign diff = 17'(b) - 17'(a);
  assign prod_nxt = 34'(diff * $signed({1'b0, frac}));
  assign v = prod_r + (34'(a) <<< 16);
  assign term = 52'(v * $signed({1'b0, vol}));

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    en_d_r <= ctl.en;
    right_d_r <= ctl.right;
    if (ctl.clr) begin
      accl_r <= '0;
      accr_r <= '0;
    end else if (en_d_r) begin
      if (right_d_r) accr_r <= accr_r + 55'(term);
      else accl_r <= accl_r + 55'(term);
    end
  end

  function automatic logic signed [15:0] to_out(input logic signed [54:0] acc);
    logic signed [54:0] c;
    logic signed [70:0] m;
    logic [70:0] mag;
    begin
      c = acc;
      if (acc > (55'sd1 <<< 46)) c = 55'sd1 <<< 46;
      if (acc < -(55'sd1 <<< 46)) c = -(55'sd1 <<< 46);
      m = 71'(c) * 71'sd32767;
      mag = m[70] ? 71'(-m) : 71'(m);
      mag = mag >> 46;
      to_out = m[70] ? -16'(mag) : 16'(mag);
    end
  endfunction

  assign ql = to_out(accl_r);
  assign qr = to_out(accr_r);
  assign left_q = ql;
  assign right_q = qr;
endmodule

// ===== hw/rtl/resampling_voice_mixer_unit.sv =====
// Resampling voice mixer, top level: voice table, sequencer, sample RAM and mac.
// Depends on rvm_pkg, rvm_ram, rvm_mac and assert_macros.svh.
//
// Use: one input channel (in_valid/in_ready) takes write, start, stop and tick
// items; one result channel (out_valid/out_ready) returns a mixed frame for
// stop and tick items only. Write and start items leave the block idle and can
// follow back to back. A stop item passes through S_OUT, which registers its result.
// A tick walks the eight voices one after another through the single sample
// RAM port and the one multiply-accumulate unit: an idle or ending voice takes
// S_CHK and S_FIN, a mono voice S_CHK, S_RDA, S_RDB, S_MAC and S_FIN, and a stereo
// voice runs S_RDA, S_RDB and S_MAC once per channel (two reads, then the mac).
// After the last voice the result is registered in S_OUT.
// Items are taken one at a time; in_ready is low while a tick or stop is
// processed or a result waits in the output register, so the next item
// transfers in the cycle after the result transfer at the earliest.
// Reset (rst_n low, synchronous) stops all voices, sets master volume to unity
// and empties the output register. Sample RAM contents are not cleared.
// When the receiver stalls, the result holds in out_* and no new item is taken
// until it is transferred.
// cfg_we writes master volume at once; write it only while idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module resampling_voice_mixer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_voice,
  input  logic [15:0] in_address,
  input  logic signed [15:0] in_sample_value,
  input  logic [15:0] in_frame_count,
  input  logic        in_stereo,
  input  logic [23:0] in_phase_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  output logic [7:0]  out_finished_mask,
  output logic [7:0]  out_active_mask,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CHK  = 7'b0000010,
    S_RDA  = 7'b0000100,
    S_RDB  = 7'b0001000,
    S_MAC  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] vol_r;
  logic [rvm_pkg::VOICES-1:0] play_r, ster_r;
  logic [15:0] base_r [rvm_pkg::VOICES];
  logic [15:0] frm_r  [rvm_pkg::VOICES];
  logic [23:0] step_r [rvm_pkg::VOICES];
  logic [31:0] ph_r   [rvm_pkg::VOICES];
  logic [rvm_pkg::VW-1:0] v_r;
  logic ch_r;
  logic [7:0] fin_r;
  logic signed [15:0] a_r;
  logic signed [15:0] rd;
  logic [15:0] ram_addr, ofs;
  logic ram_we;
  logic [2:0] wait_r;
  logic ovalid_r;
  logic signed [15:0] ol_r, or_r;
  logic [7:0] ofin_r, oact_r;
  logic [16:0] vol_eff;
  logic signed [15:0] ql, qr;
  logic [15:0] p;
  logic last_ch;
  rvm_pkg::mac_ctl_t mctl;

  assign vol_eff = ({1'b0, vol_r} > rvm_pkg::VOL_UNITY) ? rvm_pkg::VOL_UNITY : {1'b0, vol_r};
  assign p = ph_r[v_r][31:16];
  assign last_ch = !ster_r[v_r] || ch_r;
  assign in_ready = (state_r == S_IDLE) && !ovalid_r;

  // word offset of frame p (+1 frame when reading b, held through the mac cycles)
  always_comb begin
    logic [15:0] fp;
    fp = (state_r == S_RDB || state_r == S_MAC) ? p + 16'd1 : p;
    ofs = ster_r[v_r] ? {fp[14:0], ch_r} : fp;
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = base_r[v_r] + ofs;
    if (state_r == S_IDLE && in_valid && in_ready && in_action == rvm_pkg::ACT_WRITE) begin
      ram_we = 1'b1;
      ram_addr = in_address;
    end
  end

  rvm_ram #(.WIDTH(16), .DEPTH(rvm_pkg::SAMPLE_WORDS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_sample_value), .rdata(rd)
  );

  always_comb begin
    mctl.clr = (state_r == S_IDLE);
    mctl.en = (state_r == S_MAC) && (wait_r == 3'd0);
    mctl.right = ch_r;
  end

  rvm_mac u_mac (
    .clk(clk), .ctl(mctl), .a(a_r), .b(rd), .frac(ph_r[v_r][15:0]), .vol(vol_eff),
    .left_q(ql), .right_q(qr)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        if (in_action == rvm_pkg::ACT_TICK) state_nxt = S_CHK;
        else if (in_action == rvm_pkg::ACT_STOP) state_nxt = S_OUT;
      end
      S_CHK: begin
        if (!play_r[v_r] || (17'(p) + 17'd1 >= 17'(frm_r[v_r]))) state_nxt = S_FIN;
        else state_nxt = S_RDA;
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: state_nxt = S_MAC;
      S_MAC: if (wait_r == 3'd0) state_nxt = last_ch ? S_FIN : S_RDA;
      S_FIN: state_nxt = (v_r == rvm_pkg::VW'(rvm_pkg::VOICES - 1)) ? S_OUT : S_CHK;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vol_r <= 16'd32768;
      play_r <= '0;
      ovalid_r <= 1'b0;
      v_r <= '0;
      ch_r <= 1'b0;
      fin_r <= '0;
      wait_r <= '0;
      for (int i = 0; i < rvm_pkg::VOICES; i++) begin
        base_r[i] <= '0; frm_r[i] <= '0; step_r[i] <= '0; ph_r[i] <= '0;
      end
      ster_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) vol_r <= cfg_wdata;
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          v_r <= '0; ch_r <= 1'b0;
          fin_r <= (in_action == rvm_pkg::ACT_STOP) ? play_r : '0;
          if (in_action == rvm_pkg::ACT_START) begin
            play_r[in_voice] <= 1'b1;
            base_r[in_voice] <= in_address;
            frm_r[in_voice] <= in_frame_count;
            ster_r[in_voice] <= in_stereo;
            step_r[in_voice] <= in_phase_step;
            ph_r[in_voice] <= '0;
          end else if (in_action == rvm_pkg::ACT_STOP) begin
            play_r <= '0;
          end
        end
        S_CHK: begin
          ch_r <= 1'b0;
          if (play_r[v_r] && (17'(p) + 17'd1 >= 17'(frm_r[v_r]))) begin
            play_r[v_r] <= 1'b0;
            fin_r[v_r] <= 1'b1;
          end
        end
        S_RDA: ;
        S_RDB: begin
          a_r <= rd;
          wait_r <= 3'd2;
        end
        S_MAC: begin
          if (wait_r != 3'd0) wait_r <= wait_r - 3'd1;
          else if (last_ch) ph_r[v_r] <= ph_r[v_r] + 32'(step_r[v_r]);
          else ch_r <= 1'b1;
        end
        S_FIN: v_r <= v_r + 1'b1;
        S_OUT: begin
          ovalid_r <= 1'b1;
          ol_r <= ql;
          or_r <= qr;
          ofin_r <= fin_r;
          oact_r <= play_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ovalid_r;
  assign out_left_sample = ol_r;
  assign out_right_sample = or_r;
  assign out_finished_mask = ofin_r;
  assign out_active_mask = oact_r;

  `RVM_ASSERT_IMP(a_no_take_busy, state_r != S_IDLE, !in_ready)
  `RVM_ASSERT_IMP(a_fin_inactive, ovalid_r, (ofin_r & oact_r) == 8'd0)
  `RVM_ASSERT_NXT(a_out_after, state_r == S_OUT, ovalid_r)
endmodule

// ===== test/rvm_mix_checker.sv =====
// Scoreboard for the resampling voice mixer: watches the item, result and
// volume ports, predicts each mixed frame and compares it. Depends on rvm_pkg.
`timescale 1ns / 1ps
module rvm_mix_checker
  import rvm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [2:0]         in_voice,
  input  logic [15:0]        in_address,
  input  logic signed [15:0] in_sample_value,
  input  logic [15:0]        in_frame_count,
  input  logic               in_stereo,
  input  logic [23:0]        in_phase_step,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_left_sample,
  input  logic signed [15:0] out_right_sample,
  input  logic [7:0]         out_finished_mask,
  input  logic [7:0]         out_active_mask,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output int                 errors,
  output int                 pending,
  output int                 frames_checked
);

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [7:0]         finished;
    logic [7:0]         active;
  } mix_frame_t;

  mix_frame_t         frames_due[$];
  logic signed [15:0] pcm_words [0:SAMPLE_WORDS-1];
  logic [VOICES-1:0]  playing;
  logic [15:0]        v_base   [VOICES];
  logic [15:0]        v_frames [VOICES];
  logic               v_stereo [VOICES];
  logic [23:0]        v_step   [VOICES];
  logic [31:0]        v_phase  [VOICES];
  logic [15:0]        gain;

  initial begin
    errors = 0;
    pending = 0;
    frames_checked = 0;
  end

  function automatic longint word_at(logic [15:0] base, int unsigned off);
    logic [15:0] a;
    a = base + off[15:0];
    return longint'(pcm_words[a]);
  endfunction

  // a*2^16 + (b-a)*frac, the interpolated word in Q16
  function automatic longint interp(logic [15:0] base, int unsigned off0,
                                    int unsigned off1, logic [15:0] frac);
    longint a;
    longint b;
    a = word_at(base, off0);
    b = word_at(base, off1);
    return a * 65536 + (b - a) * longint'({1'b0, frac});
  endfunction

  // unity is 2^46; clip, then scale by 32767/32768 truncating toward zero
  function automatic logic [15:0] to_pcm(longint acc);
    longint one;
    longint r;
    one = longint'(1) << 46;
    if (acc > one) acc = one;
    if (acc < -one) acc = -one;
    r = (acc * 32767) / one;
    return r[15:0];
  endfunction

  task automatic mix_next_frame(input logic [1:0] act, output mix_frame_t f);
    longint      l_acc;
    longint      r_acc;
    longint      vol;
    int unsigned p;
    logic [15:0] frac;
    l_acc = 0;
    r_acc = 0;
    f = '0;
    vol = (gain > 16'd32768) ? 32768 : longint'({1'b0, gain});
    if (act == ACT_STOP) begin
      f.finished = playing;
      playing = '0;
    end else begin
      for (int v = 0; v < VOICES; v++) begin
        if (!playing[v]) continue;
        p = v_phase[v] >> 16;
        frac = v_phase[v][15:0];
        if (p + 1 >= v_frames[v]) begin
          playing[v] = 1'b0;
          f.finished[v] = 1'b1;
          continue;
        end
        if (v_stereo[v]) begin
          l_acc += interp(v_base[v], 2 * p, 2 * p + 2, frac) * vol;
          r_acc += interp(v_base[v], 2 * p + 1, 2 * p + 3, frac) * vol;
        end else begin
          l_acc += interp(v_base[v], p, p + 1, frac) * vol;
        end
        v_phase[v] = v_phase[v] + v_step[v];
      end
    end
    f.left = to_pcm(l_acc);
    f.right = to_pcm(r_acc);
    f.active = playing;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    mix_frame_t f;
    if (!rst_n) begin
      playing = '0;
      gain = 16'd32768;
      frames_due.delete();
      for (int v = 0; v < VOICES; v++) begin
        v_base[v] = '0;
        v_frames[v] = '0;
        v_stereo[v] = 1'b0;
        v_step[v] = '0;
        v_phase[v] = '0;
      end
    end else begin
      if (cfg_we) gain = cfg_wdata;
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          report("unexpected result transfer", 1, 0);
        end else begin
          f = frames_due.pop_front();
          frames_checked++;
          if (out_left_sample !== f.left)
            report("left_sample", out_left_sample, f.left);
          if (out_right_sample !== f.right)
            report("right_sample", out_right_sample, f.right);
          if (out_finished_mask !== f.finished)
            report("finished_mask", out_finished_mask, f.finished);
          if (out_active_mask !== f.active)
            report("active_mask", out_active_mask, f.active);
        end
      end
      if (in_valid && in_ready) begin
        case (in_action)
          ACT_WRITE: pcm_words[in_address] = in_sample_value;
          ACT_START: begin
            playing[in_voice] = 1'b1;
            v_base[in_voice] = in_address;
            v_frames[in_voice] = in_frame_count;
            v_stereo[in_voice] = in_stereo;
            v_step[in_voice] = in_phase_step;
            v_phase[in_voice] = '0;
          end
          default: begin
            mix_next_frame(in_action, f);
            frames_due = {frames_due, f};
          end
        endcase
      end
    end
    pending = frames_due.size();
  end

endmodule

// ===== test/resampling_voice_mixer_unit_tb.sv =====
// Testbench top for resampling_voice_mixer_unit: drives items, volume writes
// and result back-pressure; rvm_mix_checker does the checking. Depends on rvm_pkg.
`timescale 1ns / 1ps
module resampling_voice_mixer_unit_tb;
  import rvm_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_action = ACT_WRITE;
  logic [2:0]         in_voice = '0;
  logic [15:0]        in_address = '0;
  logic signed [15:0] in_sample_value = '0;
  logic [15:0]        in_frame_count = '0;
  logic               in_stereo = 1'b0;
  logic [23:0]        in_phase_step = 24'd1;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_left_sample;
  logic signed [15:0] out_right_sample;
  logic [7:0]         out_finished_mask;
  logic [7:0]         out_active_mask;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_wdata = '0;

  int errors;
  int pending;
  int frames_checked;
  int items_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  // stimulus-side shadow of the voice slots, only to know which words a tick reads
  bit          written [0:SAMPLE_WORDS-1];
  bit          sh_play   [VOICES];
  logic [15:0] sh_base   [VOICES];
  logic [15:0] sh_frames [VOICES];
  bit          sh_stereo [VOICES];
  logic [23:0] sh_step   [VOICES];
  logic [31:0] sh_phase  [VOICES];

  resampling_voice_mixer_unit u_top (.*);

  rvm_mix_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 17);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 3000) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [2:0] voice,
                           input logic [15:0] addr, input logic [15:0] value,
                           input logic [15:0] frames, input logic st,
                           input logic [23:0] step);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_voice <= voice;
    in_address <= addr;
    in_sample_value <= value;
    in_frame_count <= frames;
    in_stereo <= st;
    in_phase_step <= step;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic feed_word(input logic [15:0] addr, input logic [15:0] value);
    send_item(ACT_WRITE, 3'($urandom), addr, value, 16'($urandom), 1'($urandom),
              24'($urandom));
    written[addr] = 1'b1;
  endtask

  task automatic start_voice(input logic [2:0] voice, input logic [15:0] base,
                             input logic [15:0] frames, input logic st,
                             input logic [23:0] step);
    send_item(ACT_START, voice, base, 16'($urandom), frames, st, step);
    sh_play[voice] = 1'b1;
    sh_base[voice] = base;
    sh_frames[voice] = frames;
    sh_stereo[voice] = st;
    sh_step[voice] = step;
    sh_phase[voice] = '0;
  endtask

  task automatic stop_voices();
    send_item(ACT_STOP, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              1'($urandom), 24'($urandom));
    foreach (sh_play[v]) sh_play[v] = 1'b0;
  endtask

  // fill any word this tick will read before sending it
  task automatic tick_frame();
    int unsigned p;
    int unsigned first;
    logic [15:0] a;
    for (int v = 0; v < VOICES; v++) begin
      if (!sh_play[v]) continue;
      p = sh_phase[v] >> 16;
      if (p + 1 >= sh_frames[v]) continue;
      first = sh_stereo[v] ? 2 * p : p;
      for (int k = 0; k < (sh_stereo[v] ? 4 : 2); k++) begin
        a = sh_base[v] + 16'(first + k);
        if (!written[a]) feed_word(a, 16'($urandom));
      end
    end
    send_item(ACT_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              1'($urandom), 24'($urandom));
    for (int v = 0; v < VOICES; v++) begin
      if (!sh_play[v]) continue;
      p = sh_phase[v] >> 16;
      if (p + 1 >= sh_frames[v]) sh_play[v] = 1'b0;
      else sh_phase[v] = sh_phase[v] + sh_step[v];
    end
  endtask

  // let the block drain: write and start items leave no result behind them
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0 || !in_ready);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_volume(input logic [15:0] vol);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= vol;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    int r;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        feed_word(16'($urandom), 16'($urandom));
      end else if (r < 30) begin
        start_voice(3'($urandom), 16'($urandom),
                    ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                    1'($urandom),
                    ($urandom_range(0, 6) == 0) ? 24'($urandom_range(1, 24'hFFFFFF))
                                                : 24'($urandom_range(24'h2000, 24'h30000)));
        repeat ($urandom_range(1, 10)) tick_frame();
      end else if (r < 33) begin
        stop_voices();
      end else begin
        tick_frame();
      end
    end
  endtask

  initial begin
    logic [15:0] vols [5];
    vols = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 32767)), 16'd32768};
    foreach (sh_play[v]) sh_play[v] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, wrap of the word address, short voices, slot reuse
    set_volume(16'd32768);
    feed_word(16'hFFFF, 16'sh7FFF);
    feed_word(16'h0000, 16'sh8000);
    start_voice(3'd0, 16'hFFFF, 16'd2, 1'b0, 24'h008000);
    tick_frame();
    tick_frame();
    start_voice(3'd1, 16'hFFFE, 16'd3, 1'b1, 24'h010000);
    start_voice(3'd2, 16'h1234, 16'd0, 1'b0, 24'h010000);
    start_voice(3'd3, 16'h2345, 16'd1, 1'b1, 24'h010000);
    start_voice(3'd7, 16'h8000, 16'hFFFF, 1'b1, 24'hFFFFFF);
    start_voice(3'd4, 16'h4000, 16'd5, 1'b0, 24'd1);
    start_voice(3'd4, 16'h4100, 16'd4, 1'b0, 24'h00C000);
    tick_frame();
    tick_frame();
    tick_frame();
    stop_voices();
    tick_frame();
    stop_voices();

    foreach (vols[i]) begin
      set_volume(vols[i]);
      if (i == 4) quiet = 1'b1;
      random_traffic(200);
    end

    settle();
    $display("sent %0d items, checked %0d mixed frames", items_sent, frames_checked);
    $display("volume settings 0, 1, mid, unity and over-range; mono, stereo, short voices");
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rvm_pkg.sv
hw/rtl/rvm_ram.sv
hw/rtl/rvm_mac.sv
hw/rtl/resampling_voice_mixer_unit.sv
test/rvm_mix_checker.sv
test/resampling_voice_mixer_unit_tb.sv
